// ===== rtl/core/ddplf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddplf_pkg
// Shared constants for the DDP LED packet framer: header codes, register
// indexes and the beat codes used to walk through a datagram header.
// ----------------------------------------------------------------------------
package ddplf_pkg;

	// default datagram payload size in channel bytes
	localparam int PACKET_CHANNELS_DEF = 1440;

	localparam int COUNT_W = 16;
	localparam int BYTE_W  = 8;
	localparam int SEQ_W   = 4;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [3:0]        beat_t;
	typedef logic [0:0]        reg_index_t;

	// configuration register indexes
	localparam reg_index_t REG_CHANNEL_COUNT = 1'd0;
	localparam reg_index_t REG_RGBW_MODE     = 1'd1;

	localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 16'd3;

	// header byte codes
	localparam byte_t HDR_VERSION    = 8'h40;
	localparam byte_t HDR_PUSH       = 8'h01;
	localparam byte_t HDR_DISPLAY_ID = 8'h01;
	localparam byte_t TYPE_RGB8      = 8'h8B;
	localparam byte_t TYPE_RGBW8     = 8'h9B;
	localparam byte_t BYTE_ZERO      = 8'h00;

	// output beats of a transaction that opens a datagram: ten header bytes then the data byte
	localparam beat_t BEAT_FLAGS = 4'd0;
	localparam beat_t BEAT_SEQ   = 4'd1;
	localparam beat_t BEAT_TYPE  = 4'd2;
	localparam beat_t BEAT_ID    = 4'd3;
	localparam beat_t BEAT_OFF3  = 4'd4;
	localparam beat_t BEAT_OFF2  = 4'd5;
	localparam beat_t BEAT_OFF1  = 4'd6;
	localparam beat_t BEAT_OFF0  = 4'd7;
	localparam beat_t BEAT_LEN1  = 4'd8;
	localparam beat_t BEAT_LEN0  = 4'd9;
	localparam beat_t BEAT_DATA  = 4'd10;

endpackage

// ===== rtl/core/ddp_led_packet_framer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_led_packet_framer_unit
// Splits a frame of LED channel bytes into DDP datagrams, putting a 10-byte
// header ahead of the first data byte of each datagram.
// ----------------------------------------------------------------------------
// path: an input byte goes through the item register, then the output register
// throughput: 1 channel byte per cycle inside a datagram while out_ready holds;
//   a byte that opens a datagram stalls the input for its ten header bytes
// reset: arst_n clears frame, datagram and sequence state, channel_count
//   returns to 3 and rgbw_mode to 0; no clearing pass
module ddp_led_packet_framer_unit #(
	parameter int PACKET_CHANNELS = ddplf_pkg::PACKET_CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_write,
	input  ddplf_pkg::reg_index_t          cfg_index,
	input  logic [ddplf_pkg::COUNT_W-1:0]  cfg_data,
	// channel byte input
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ddplf_pkg::BYTE_W-1:0]   channel_value,
	// datagram byte output
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ddplf_pkg::BYTE_W-1:0]   out_byte,
	output logic                           datagram_end,
	output logic                           run_last
);

	localparam int PW = (PACKET_CHANNELS > 1) ? $clog2(PACKET_CHANNELS + 1) : 1;
	localparam int CW = ddplf_pkg::COUNT_W;

	// configuration registers
	logic [CW-1:0] channel_count_q;
	logic          rgbw_mode_q;

	// framing state
	logic [CW-1:0]                 frame_pos_q;
	logic [PW-1:0]                 pkt_pos_q;
	logic [ddplf_pkg::SEQ_W-1:0]   seq_q;

	// item register
	logic                          item_valid_s1;
	ddplf_pkg::beat_t              beat_s1;
	ddplf_pkg::byte_t              data_s1;
	logic                          last_s1;
	logic [ddplf_pkg::SEQ_W-1:0]   seq_s1;
	logic                          rgbw_s1;
	logic [CW-1:0]                 offset_s1;
	logic [PW-1:0]                 size_s1;
	logic                          pkt_end_s1;

	// output register
	logic                          out_valid_q;
	ddplf_pkg::byte_t              out_byte_q;
	logic                          dend_q;
	logic                          last_q;

	logic                          in_acc;
	logic                          out_load;
	logic                          move;
	logic                          is_data;
	logic                          open_pkt;
	logic [CW-1:0]                 rem;
	logic                          last_pkt;
	logic [PW-1:0]                 size;
	logic                          frame_end;
	logic                          pkt_end;
	logic [CW-1:0]                 size_w;
	ddplf_pkg::byte_t              beat_byte;

	assign out_load = !out_valid_q || out_ready;
	assign is_data  = (beat_s1 == ddplf_pkg::BEAT_DATA);
	assign move     = item_valid_s1 && out_load;
	assign in_ready = !item_valid_s1 || (out_load && is_data);
	assign in_acc   = in_valid && in_ready;

	// header fields for a transaction that opens a datagram, and frame and datagram end flags
	always_comb begin
		open_pkt  = (pkt_pos_q == '0);
		rem       = (channel_count_q > frame_pos_q) ? (channel_count_q - frame_pos_q)
		                                            : CW'(1);
		last_pkt  = ({1'b0, rem} <= (CW+1)'(PACKET_CHANNELS));
		size      = last_pkt ? rem[PW-1:0] : PW'(PACKET_CHANNELS);
		frame_end = (({1'b0, frame_pos_q} + (CW+1)'(1)) >= {1'b0, channel_count_q});
		pkt_end   = frame_end
		            || (({1'b0, pkt_pos_q} + (PW+1)'(1)) >= (PW+1)'(PACKET_CHANNELS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= ddplf_pkg::CHANNEL_COUNT_RST;
			rgbw_mode_q     <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ddplf_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data;
				ddplf_pkg::REG_RGBW_MODE:     rgbw_mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q <= '0;
			pkt_pos_q   <= '0;
			seq_q       <= '0;
		end else if (in_acc) begin
			if (open_pkt) begin
				seq_q <= seq_q + 1'b1;
			end
			if (frame_end) begin
				frame_pos_q <= '0;
				pkt_pos_q   <= '0;
			end else begin
				frame_pos_q <= frame_pos_q + 1'b1;
				pkt_pos_q   <= pkt_end ? '0 : pkt_pos_q + 1'b1;
			end
		end
	end

	// item register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			beat_s1       <= ddplf_pkg::BEAT_FLAGS;
		end else if (in_acc) begin
			item_valid_s1 <= 1'b1;
			beat_s1       <= open_pkt ? ddplf_pkg::BEAT_FLAGS : ddplf_pkg::BEAT_DATA;
		end else if (move) begin
			if (is_data) begin
				item_valid_s1 <= 1'b0;
			end else begin
				beat_s1 <= beat_s1 + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1    <= channel_value;
			last_s1    <= last_pkt;
			seq_s1     <= seq_q;
			rgbw_s1    <= rgbw_mode_q;
			offset_s1  <= frame_pos_q;
			size_s1    <= size;
			pkt_end_s1 <= pkt_end;
		end
	end

	assign size_w = CW'(size_s1);

	always_comb begin
		unique case (beat_s1) inside
			ddplf_pkg::BEAT_FLAGS:
				beat_byte = ddplf_pkg::HDR_VERSION | (last_s1 ? ddplf_pkg::HDR_PUSH
				                                            : ddplf_pkg::BYTE_ZERO);
			ddplf_pkg::BEAT_SEQ:
				beat_byte = ddplf_pkg::byte_t'(seq_s1);
			ddplf_pkg::BEAT_TYPE:
				beat_byte = rgbw_s1 ? ddplf_pkg::TYPE_RGBW8 : ddplf_pkg::TYPE_RGB8;
			ddplf_pkg::BEAT_ID:
				beat_byte = ddplf_pkg::HDR_DISPLAY_ID;
			// offset is below 64k, so its top two bytes are zero
			ddplf_pkg::BEAT_OFF3, ddplf_pkg::BEAT_OFF2:
				beat_byte = ddplf_pkg::BYTE_ZERO;
			ddplf_pkg::BEAT_OFF1:
				beat_byte = offset_s1[15:8];
			ddplf_pkg::BEAT_OFF0:
				beat_byte = offset_s1[7:0];
			ddplf_pkg::BEAT_LEN1:
				beat_byte = size_w[15:8];
			ddplf_pkg::BEAT_LEN0:
				beat_byte = size_w[7:0];
			default:
				beat_byte = data_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_byte_q <= beat_byte;
			dend_q     <= is_data && pkt_end_s1;
			last_q     <= is_data;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign datagram_end = dend_q;
	assign run_last     = last_q;

`ifndef SYNTHESIS
	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 |-> (beat_s1 <= ddplf_pkg::BEAT_DATA))
		else $error("beat counter ran past the data beat");

	a_dend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && datagram_end) |-> run_last)
		else $error("datagram end flagged on a header byte");

	a_pkt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, pkt_pos_q} < (PW+1)'(PACKET_CHANNELS)))
		else $error("datagram position reached the datagram size");

	a_open_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (pkt_pos_q == '0)) |=>
			(item_valid_s1 && (beat_s1 == ddplf_pkg::BEAT_FLAGS)))
		else $error("datagram opened without a header");
`endif

endmodule
